FILE: hw/rtl/cua_pkg.sv
// Shared types and constants for the checked unsigned 64-bit ALU.
// No dependencies; every other file of the block imports this package.
package cua_pkg;

	localparam int unsigned DATA_W     = 64;
	localparam int unsigned DIV_STAGES = 64;
	localparam int unsigned MUL_STAGES = 3;
	localparam int unsigned S_TDATA_W  = 136;
	localparam int unsigned M_TDATA_W  = 72;

	typedef enum logic [3:0] {
		OP_EQ  = 4'd0,
		OP_NE  = 4'd1,
		OP_LT  = 4'd2,
		OP_GT  = 4'd3,
		OP_LE  = 4'd4,
		OP_GE  = 4'd5,
		OP_ADD = 4'd6,
		OP_SUB = 4'd7,
		OP_MUL = 4'd8,
		OP_DIV = 4'd9,
		OP_MOD = 4'd10,
		OP_MAX = 4'd11,
		OP_MIN = 4'd12,
		OP_INC = 4'd13
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_DIVZERO = 2'd2
	} status_t;

	// Result of the combinational operations, carried alongside the long divider.
	typedef struct packed {
		logic [3:0]        op;
		logic              b_zero;
		logic [DATA_W-1:0] val;
		status_t           st;
	} side_t;

	typedef struct packed {
		logic [DATA_W-1:0] lo;
		logic              ovf;
	} mul_res_t;

endpackage

FILE: hw/rtl/checked_unsigned_alu_64.sv
// Checked unsigned 64-bit ALU: one result per transaction, one transaction per cycle
// sustained unless the output stalls; the depth is set by the bit-per-stage divider;
// all operations travel the same pipeline so results leave in order. The whole pipe
// advances together whenever the output register is empty or being taken.
// Depends on cua_pkg, cua_mul and cua_div.
module checked_unsigned_alu_64 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [3:0] operation, [67:4] operand_a, [131:68] operand_b, rest zero
	input  logic [cua_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [63:0] result_value, [65:64] status, rest zero
	output logic [cua_pkg::M_TDATA_W-1:0] m_tdata
);
	import cua_pkg::*;

	logic en;
	logic [DIV_STAGES:0] vld_q;  // index 0 is stage 1
	logic [3:0]          op_s1;
	logic [DATA_W-1:0]   a_s1, b_s1;
	side_t               side_c;
	side_t               side_q [DIV_STAGES];
	mul_res_t            mul_res;
	mul_res_t            mul_q [DIV_STAGES-MUL_STAGES];
	logic [DATA_W-1:0]   quo, rem;
	logic                m_tvalid_q;
	logic [DATA_W-1:0]   val_q;
	status_t             st_q;
	logic [DATA_W-1:0]   fin_val;
	status_t             fin_st;

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			vld_q      <= {vld_q[DIV_STAGES-1:0], s_tvalid};
			m_tvalid_q <= vld_q[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= s_tdata[3:0];
			a_s1  <= s_tdata[67:4];
			b_s1  <= s_tdata[131:68];
		end
	end

	// combinational operations
	always_comb begin
		logic [DATA_W:0] sum;
		logic [DATA_W:0] diff;
		logic [DATA_W:0] incr;
		sum  = {1'b0, a_s1} + {1'b0, b_s1};
		diff = {1'b0, a_s1} - {1'b0, b_s1};
		incr = {1'b0, a_s1} + {{DATA_W{1'b0}}, 1'b1};
		side_c.op     = op_s1;
		side_c.b_zero = (b_s1 == '0);
		side_c.val    = '0;
		side_c.st     = ST_OK;
		case (op_s1)
			OP_EQ: side_c.val = {{(DATA_W-1){1'b0}}, a_s1 == b_s1};
			OP_NE: side_c.val = {{(DATA_W-1){1'b0}}, a_s1 != b_s1};
			OP_LT: side_c.val = {{(DATA_W-1){1'b0}}, diff[DATA_W]};
			OP_GT: side_c.val = {{(DATA_W-1){1'b0}}, a_s1 > b_s1};
			OP_LE: side_c.val = {{(DATA_W-1){1'b0}}, a_s1 <= b_s1};
			OP_GE: side_c.val = {{(DATA_W-1){1'b0}}, !diff[DATA_W]};
			OP_ADD: begin
				if (sum[DATA_W]) side_c.st = ST_RANGE;
				else side_c.val = sum[DATA_W-1:0];
			end
			OP_SUB: begin
				if (diff[DATA_W]) side_c.st = ST_RANGE;
				else side_c.val = diff[DATA_W-1:0];
			end
			OP_MAX: side_c.val = (a_s1 > b_s1) ? a_s1 : b_s1;
			OP_MIN: side_c.val = (a_s1 < b_s1) ? a_s1 : b_s1;
			OP_INC: begin
				if (incr[DATA_W]) side_c.st = ST_RANGE;
				else side_c.val = incr[DATA_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) side_q[0] <= side_c;
	end
	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) side_q[k] <= side_q[k-1];
		end
	end

	cua_mul u_mul (
		.clk (clk),
		.en  (en),
		.a   (a_s1),
		.b   (b_s1),
		.res (mul_res)
	);

	always_ff @(posedge clk) begin
		if (en) mul_q[0] <= mul_res;
	end
	for (genvar k = 1; k < DIV_STAGES - MUL_STAGES; k++) begin : g_mul
		always_ff @(posedge clk) begin
			if (en) mul_q[k] <= mul_q[k-1];
		end
	end

	cua_div u_div (
		.clk       (clk),
		.en        (en),
		.dividend  (a_s1),
		.divisor   (b_s1),
		.quotient  (quo),
		.remainder (rem)
	);

	// merge at the last stage
	always_comb begin
		fin_val = side_q[DIV_STAGES-1].val;
		fin_st  = side_q[DIV_STAGES-1].st;
		case (side_q[DIV_STAGES-1].op)
			OP_MUL: begin
				if (mul_q[DIV_STAGES-MUL_STAGES-1].ovf) begin
					fin_val = '0;
					fin_st  = ST_RANGE;
				end else begin
					fin_val = mul_q[DIV_STAGES-MUL_STAGES-1].lo;
					fin_st  = ST_OK;
				end
			end
			OP_DIV, OP_MOD: begin
				if (side_q[DIV_STAGES-1].b_zero) begin
					fin_val = '0;
					fin_st  = ST_DIVZERO;
				end else begin
					fin_val = (side_q[DIV_STAGES-1].op == OP_DIV) ? quo : rem;
					fin_st  = ST_OK;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= fin_val;
			st_q  <= fin_st;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W-DATA_W-2){1'b0}}, st_q, val_q};

endmodule

FILE: hw/rtl/cua_mul.sv
// Three-stage 64x64 multiplier built from four 32x32 partial products.
// Gives the low 64 bits of the product and an overflow flag. Uses cua_pkg.
module cua_mul (
	input  logic                      clk,
	input  logic                      en,
	input  logic [cua_pkg::DATA_W-1:0] a,
	input  logic [cua_pkg::DATA_W-1:0] b,
	output cua_pkg::mul_res_t          res
);
	import cua_pkg::*;

	localparam int unsigned HW = DATA_W / 2;

	logic [DATA_W-1:0]   ll_s1, lh_s1, hl_s1, hh_s1;
	logic [DATA_W:0]     mid_s2;
	logic [DATA_W-1:0]   ll_s2;
	logic                hh_nz_s2;
	logic [DATA_W+HW:0]  sum;
	mul_res_t            res_s3;

	assign sum = {mid_s2, {HW{1'b0}}} + {{(HW+1){1'b0}}, ll_s2};

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1    <= a[HW-1:0]      * b[HW-1:0];
			lh_s1    <= a[HW-1:0]      * b[DATA_W-1:HW];
			hl_s1    <= a[DATA_W-1:HW] * b[HW-1:0];
			hh_s1    <= a[DATA_W-1:HW] * b[DATA_W-1:HW];
			mid_s2   <= {1'b0, lh_s1} + {1'b0, hl_s1};
			ll_s2    <= ll_s1;
			hh_nz_s2 <= (hh_s1 != '0);
			res_s3.lo  <= sum[DATA_W-1:0];
			res_s3.ovf <= hh_nz_s2 || (sum[DATA_W+HW:DATA_W] != '0);
		end
	end

	assign res = res_s3;

endmodule

FILE: hw/rtl/cua_div.sv
// Restoring divider, one quotient bit per pipeline stage, DIV_STAGES stages.
// Gives quotient and remainder; a zero divisor gives junk the caller masks. Uses cua_pkg.
module cua_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [cua_pkg::DATA_W-1:0] dividend,
	input  logic [cua_pkg::DATA_W-1:0] divisor,
	output logic [cua_pkg::DATA_W-1:0] quotient,
	output logic [cua_pkg::DATA_W-1:0] remainder
);
	import cua_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] num;  // dividend shifts out, quotient shifts in
		logic [DATA_W-1:0] d;
	} dstage_t;

	function automatic dstage_t div_step(dstage_t x);
		dstage_t        y;
		logic [DATA_W:0] t;
		logic [DATA_W:0] diff;
		t    = {x.rem, x.num[DATA_W-1]};
		diff = t - {1'b0, x.d};
		y.d  = x.d;
		if (!diff[DATA_W]) begin
			y.rem = diff[DATA_W-1:0];
			y.num = {x.num[DATA_W-2:0], 1'b1};
		end else begin
			y.rem = t[DATA_W-1:0];
			y.num = {x.num[DATA_W-2:0], 1'b0};
		end
		return y;
	endfunction

	dstage_t stg_q [DIV_STAGES];
	dstage_t init;

	always_comb begin
		init.rem = '0;
		init.num = dividend;
		init.d   = divisor;
	end

	always_ff @(posedge clk) begin
		if (en) stg_q[0] <= div_step(init);
	end

	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) stg_q[k] <= div_step(stg_q[k-1]);
		end
	end

	assign quotient  = stg_q[DIV_STAGES-1].num;
	assign remainder = stg_q[DIV_STAGES-1].rem;

endmodule

FILE: hw/rtl/cua_checker.sv
// Port-level checks on the checked unsigned 64-bit ALU, bound to the top level.
// Depends on checked_unsigned_alu_64 and cua_pkg.
module cua_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [cua_pkg::S_TDATA_W-1:0] s_tdata,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [cua_pkg::M_TDATA_W-1:0] m_tdata
);
	import cua_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[65:64] != 2'd3)
		else $error("undefined status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65:64] != ST_OK |-> m_tdata[63:0] == '0)
		else $error("error result not zero");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:66] == '0)
		else $error("output padding not zero");

endmodule

bind checked_unsigned_alu_64 cua_checker u_cua_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/sv/tb_top.sv
// Testbench for checked_unsigned_alu_64: random and directed operand pairs, self-checking.
// Depends on cua_pkg and the block's RTL; holds its own arithmetic predictor.
`timescale 1ns / 1ps

class alu_scoreboard;
	logic [63:0] exp_val_q[$];
	logic [1:0]  exp_st_q[$];
	int unsigned n_err;
	int unsigned n_seen;
	int unsigned n_range;
	int unsigned n_divzero;

	function new();
		n_err = 0;
		n_seen = 0;
		n_range = 0;
		n_divzero = 0;
	endfunction

	// predicts value and status of one transaction
	function void note_input(logic [3:0] op, logic [63:0] a, logic [63:0] b);
		logic [63:0]  v;
		logic [1:0]   st;
		logic [64:0]  sum;
		logic [127:0] prod;
		v = '0;
		st = cua_pkg::ST_OK;
		case (op)
		cua_pkg::OP_EQ: v = {63'd0, a == b};
		cua_pkg::OP_NE: v = {63'd0, a != b};
		cua_pkg::OP_LT: v = {63'd0, a < b};
		cua_pkg::OP_GT: v = {63'd0, a > b};
		cua_pkg::OP_LE: v = {63'd0, a <= b};
		cua_pkg::OP_GE: v = {63'd0, a >= b};
		cua_pkg::OP_ADD: begin
			sum = {1'b0, a} + {1'b0, b};
			if (sum[64]) st = cua_pkg::ST_RANGE;
			else v = sum[63:0];
		end
		cua_pkg::OP_SUB: begin
			if (b > a) st = cua_pkg::ST_RANGE;
			else v = a - b;
		end
		cua_pkg::OP_MUL: begin
			prod = {64'd0, a} * {64'd0, b};
			if (prod[127:64] != 0) st = cua_pkg::ST_RANGE;
			else v = prod[63:0];
		end
		cua_pkg::OP_DIV: begin
			if (b == 0) st = cua_pkg::ST_DIVZERO;
			else v = a / b;
		end
		cua_pkg::OP_MOD: begin
			if (b == 0) st = cua_pkg::ST_DIVZERO;
			else v = a % b;
		end
		cua_pkg::OP_MAX: v = (a > b) ? a : b;
		cua_pkg::OP_MIN: v = (a < b) ? a : b;
		cua_pkg::OP_INC: begin
			if (&a) st = cua_pkg::ST_RANGE;
			else v = a + 64'd1;
		end
		default: ;
		endcase
		if (st == cua_pkg::ST_RANGE) n_range++;
		if (st == cua_pkg::ST_DIVZERO) n_divzero++;
		exp_val_q.push_back(v);
		exp_st_q.push_back(st);
	endfunction

	function void check_result(logic [71:0] d);
		logic [63:0] ev;
		logic [1:0]  es;
		n_seen++;
		if (exp_val_q.size() == 0) begin
			n_err++;
			if (n_err <= 10)
				$display("unexpected result %h", d);
			return;
		end
		ev = exp_val_q.pop_front();
		es = exp_st_q.pop_front();
		if (d[63:0] !== ev || d[65:64] !== es || d[71:66] !== 6'd0) begin
			n_err++;
			if (n_err <= 10)
				$display("mismatch #%0d: exp val %h st %0d, got val %h st %0d pad %h",
					n_seen, ev, es, d[63:0], d[65:64], d[71:66]);
		end
	endfunction

	function int pending();
		return exp_val_q.size();
	endfunction
endclass

module tb_top;
	import cua_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;

	alu_scoreboard sb;
	int unsigned   src_idle_pct;
	int unsigned   sink_stall_pct;
	int unsigned   n_sent;

	checked_unsigned_alu_64 u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("** checked_unsigned_alu_64: FAILED **");
		$finish;
	end

	// sink side: random back-pressure, checks each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	function automatic logic [63:0] rand64();
		logic [63:0] r;
		case ($urandom_range(7))
		0: r = '0;
		1: r = '1;
		2: r = 64'($urandom_range(15));
		3: r = {32'd0, $urandom()};
		4: r = {48'd0, 16'($urandom())};
		5: r = '1 - 64'($urandom_range(3));
		default: r = {$urandom(), $urandom()};
		endcase
		return r;
	endfunction

	task automatic send_item(logic [3:0] op, logic [63:0] a, logic [63:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'd0, b, a, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(op, a, b);
		n_sent++;
	endtask

	task automatic drain();
		int unsigned guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (sb.pending() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	task automatic random_items(int unsigned n);
		logic [3:0]  op;
		logic [63:0] a;
		logic [63:0] b;
		repeat (n) begin
			op = 4'($urandom_range(15));
			a = rand64();
			b = rand64();
			if ($urandom_range(9) == 0) b = a;
			// small factors now and then so products fit
			if (op == OP_MUL && $urandom_range(1)) begin
				a = {32'd0, $urandom()};
				b = {32'd0, $urandom()};
			end
			send_item(op, a, b);
		end
	endtask

	initial begin
		logic [63:0] mx;
		sb = new();
		mx = '1;
		n_sent = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each operation, field extremes and error corners
		for (int o = 0; o < 16; o++)
			send_item(o[3:0], 64'd5, 64'd7);
		send_item(OP_ADD, mx, 64'd1);
		send_item(OP_ADD, mx, 64'd0);
		send_item(OP_SUB, 64'd3, 64'd4);
		send_item(OP_SUB, mx, mx);
		send_item(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
		send_item(OP_MUL, mx, 64'd1);
		send_item(OP_DIV, mx, 64'd0);
		send_item(OP_MOD, 64'd9, 64'd0);
		send_item(OP_INC, mx, mx);
		send_item(OP_MAX, mx, mx);
		// pause until the pipe has emptied
		drain();

		src_idle_pct = 0;  sink_stall_pct = 0;  random_items(300);
		src_idle_pct = 65; sink_stall_pct = 0;  random_items(280);
		src_idle_pct = 0;  sink_stall_pct = 65; random_items(280);
		src_idle_pct = 24; sink_stall_pct = 24; random_items(290);
		drain();
		sink_stall_pct = 0;
		repeat (80) @(posedge clk);

		$display("sent %0d transactions, %0d results checked (%0d range, %0d div-by-zero)",
			n_sent, sb.n_seen, sb.n_range, sb.n_divzero);
		$display("all opcodes incl. unused ones, four idling phases; %0d left, %0d errors",
			sb.pending(), sb.n_err);
		if (sb.n_err == 0 && sb.pending() == 0)
			$display("** checked_unsigned_alu_64: PASSED **");
		else
			$display("** checked_unsigned_alu_64: FAILED **");
		$finish;
	end
endmodule
